// File: rtl/core/assert_macros.svh
// Assertion helpers for the block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/mrdd_pkg.sv
package mrdd_pkg;

   localparam int MAX_PROCESSES = 16;
   localparam int MAX_RESOURCES = 8;
   localparam int COUNT_WIDTH   = 8;

   localparam int PROC_IDX_W = $clog2(MAX_PROCESSES);
   localparam int RES_IDX_W  = $clog2(MAX_RESOURCES);
   localparam int ADDR_W     = PROC_IDX_W + RES_IDX_W;
   localparam int DEPTH      = MAX_PROCESSES * MAX_RESOURCES;
   localparam int PROC_CNT_W = $clog2(MAX_PROCESSES + 1);
   localparam int RES_CNT_W  = $clog2(MAX_RESOURCES + 1);
   localparam int AVAIL_W    = 13;

   localparam logic CSR_IDX_PROCS = 1'b0;
   localparam logic CSR_IDX_RES   = 1'b1;

   typedef enum logic [1:0] {
      KIND_EXIST   = 2'd0,
      KIND_ALLOC   = 2'd1,
      KIND_REQUEST = 2'd2,
      KIND_RUN     = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_CHECK,
      ST_DRAIN,
      ST_COMMIT,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT,
      OP_SUM,
      OP_CHECK,
      OP_COMMIT,
      OP_PASS,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type                  op;
      req_kind_type            kind;
      logic [PROC_IDX_W-1:0]   proc;
      logic [RES_IDX_W-1:0]    res;
      logic [COUNT_WIDTH-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic [MAX_PROCESSES-1:0] finished;
      logic                     progress;
   } status_type;

endpackage

// File: rtl/core/multi_resource_deadlock_detector_unit.sv
// Deadlock detector for resource types with several units each. Load requests
// (tuser 0 existing units, 1 allocation, 2 request) write one table entry
// each and are taken back to back while idle; they give no response. A run
// request (tuser 3) computes the available units per resource by walking the
// allocation table one entry a cycle, then makes passes over the processes: a
// process not yet finished takes one read of the request and allocation RAMs
// per resource, then a drain state and a commit, while a finished one is
// skipped. Passes repeat while one finishes a process, and a run ends in one
// response. The block takes no new request while a run is in progress, but a
// response left waiting in its output register does not hold off new requests.
module multi_resource_deadlock_detector_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // proc_index[3:0], res_index[6:4], value[14:7], zero
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // deadlock_found[0], deadlocked_mask[16:1],
                                    // deadlocked_count[21:17], zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mrdd_pkg::*;

   logic [4:0]            num_processes_ff, num_processes_in;
   logic [3:0]            num_resources_ff, num_resources_in;
   logic [PROC_CNT_W-1:0] rows;
   logic [RES_CNT_W-1:0]  cols;
   logic                  csr_write;

   cmd_type               cmd;
   status_type            status;
   logic                  deadlock_found;
   logic [MAX_PROCESSES-1:0] deadlocked_mask;
   logic [PROC_CNT_W-1:0] deadlocked_count;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      num_processes_in = num_processes_ff;
      num_resources_in = num_resources_ff;
      csr_prdata       = '0;
      unique case (csr_paddr[2])
         CSR_IDX_PROCS: begin
            csr_prdata = {27'd0, num_processes_ff};
            if (csr_write) begin
               num_processes_in = csr_pwdata[4:0];
            end
         end
         CSR_IDX_RES: begin
            csr_prdata = {28'd0, num_resources_ff};
            if (csr_write) begin
               num_resources_in = csr_pwdata[3:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_processes_ff <= 5'd1;
         num_resources_ff <= 4'd1;
      end else begin
         num_processes_ff <= num_processes_in;
         num_resources_ff <= num_resources_in;
      end
   end

   assign rows = (num_processes_ff > 5'(MAX_PROCESSES)) ? PROC_CNT_W'(MAX_PROCESSES)
                                                        : PROC_CNT_W'(num_processes_ff);
   assign cols = (num_resources_ff > 4'(MAX_RESOURCES)) ? RES_CNT_W'(MAX_RESOURCES)
                                                        : RES_CNT_W'(num_resources_ff);

   mrdd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_kind_type'(req_tuser)),
      .req_proc   (req_tdata[3:0]),
      .req_res    (req_tdata[6:4]),
      .req_value  (req_tdata[14:7]),
      .rows       (rows),
      .cols       (cols),
      .status     (status),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   mrdd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .rows             (rows),
      .cols             (cols),
      .status           (status),
      .deadlock_found   (deadlock_found),
      .deadlocked_mask  (deadlocked_mask),
      .deadlocked_count (deadlocked_count)
   );

   assign rsp_tdata = {2'b00, deadlocked_count, deadlocked_mask, deadlock_found};

endmodule

// File: rtl/core/mrdd_datapath.sv
module mrdd_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mrdd_pkg::cmd_type                     cmd,
   input  logic [mrdd_pkg::PROC_CNT_W-1:0]       rows,
   input  logic [mrdd_pkg::RES_CNT_W-1:0]        cols,
   output mrdd_pkg::status_type                  status,
   output logic                                  deadlock_found,
   output logic [mrdd_pkg::MAX_PROCESSES-1:0]    deadlocked_mask,
   output logic [mrdd_pkg::PROC_CNT_W-1:0]       deadlocked_count
);
   import mrdd_pkg::*;

   logic [COUNT_WIDTH-1:0] alloc_mem [DEPTH];
   logic [COUNT_WIDTH-1:0] req_mem   [DEPTH];
   logic [COUNT_WIDTH-1:0] alloc_rd_ff;
   logic [COUNT_WIDTH-1:0] req_rd_ff;
   logic [ADDR_W-1:0]      addr;

   logic [COUNT_WIDTH-1:0]    existing_ff [MAX_RESOURCES];
   logic [COUNT_WIDTH-1:0]    alloc_row_ff [MAX_RESOURCES];
   logic [COUNT_WIDTH-1:0]    alloc_row_in [MAX_RESOURCES];
   logic signed [AVAIL_W-1:0] avail_ff [MAX_RESOURCES];
   logic signed [AVAIL_W-1:0] avail_in [MAX_RESOURCES];
   logic [MAX_PROCESSES-1:0]  finished_ff, finished_in;
   logic                      progress_ff, progress_in;
   logic                      ok_ff, ok_in;
   op_type                    stage_op_ff;
   logic [RES_IDX_W-1:0]      stage_res_ff;

   logic                      found_ff, found_in;
   logic [MAX_PROCESSES-1:0]  mask_ff, mask_in;
   logic [PROC_CNT_W-1:0]     count_ff, count_in;

   logic signed [AVAIL_W-1:0] req_ext;
   logic signed [AVAIL_W-1:0] alloc_ext;
   logic [MAX_PROCESSES-1:0]  live_mask;

   assign addr      = {cmd.proc, cmd.res};
   assign req_ext   = signed'({{(AVAIL_W-COUNT_WIDTH){1'b0}}, req_rd_ff});
   assign alloc_ext = signed'({{(AVAIL_W-COUNT_WIDTH){1'b0}}, alloc_rd_ff});

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && cmd.kind == KIND_ALLOC) begin
         alloc_mem[addr] <= cmd.value;
      end
      if (cmd.op == OP_LOAD && cmd.kind == KIND_REQUEST) begin
         req_mem[addr] <= cmd.value;
      end
      alloc_rd_ff <= alloc_mem[addr];
      req_rd_ff   <= req_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && cmd.kind == KIND_EXIST) begin
         existing_ff[cmd.res] <= cmd.value;
      end
      alloc_row_ff <= alloc_row_in;
      found_ff     <= found_in;
      mask_ff      <= mask_in;
      count_ff     <= count_in;
      stage_res_ff <= cmd.res;
   end

   always_comb begin
      for (int i = 0; i < MAX_PROCESSES; i++) begin
         live_mask[i] = (PROC_CNT_W'(i) < rows);
      end
   end

   always_comb begin
      avail_in     = avail_ff;
      alloc_row_in = alloc_row_ff;
      finished_in  = finished_ff;
      progress_in  = progress_ff;
      ok_in        = ok_ff;
      found_in     = found_ff;
      mask_in      = mask_ff;
      count_in     = count_ff;

      case (stage_op_ff)
         OP_SUM: begin
            avail_in[stage_res_ff] = avail_ff[stage_res_ff] - alloc_ext;
         end
         OP_CHECK: begin
            if (req_ext > avail_ff[stage_res_ff]) begin
               ok_in = 1'b0;
            end
            alloc_row_in[stage_res_ff] = alloc_rd_ff;
         end
         default: begin
         end
      endcase

      case (cmd.op)
         OP_INIT: begin
            for (int j = 0; j < MAX_RESOURCES; j++) begin
               avail_in[j] = signed'({{(AVAIL_W-COUNT_WIDTH){1'b0}}, existing_ff[j]});
            end
            finished_in = '0;
            progress_in = 1'b0;
            ok_in       = 1'b1;
         end
         OP_COMMIT: begin
            if (ok_ff) begin
               finished_in[cmd.proc] = 1'b1;
               progress_in           = 1'b1;
               for (int j = 0; j < MAX_RESOURCES; j++) begin
                  if (RES_CNT_W'(j) < cols) begin
                     avail_in[j] = avail_ff[j] +
                        signed'({{(AVAIL_W-COUNT_WIDTH){1'b0}}, alloc_row_ff[j]});
                  end
               end
            end
            ok_in = 1'b1;
         end
         OP_PASS: begin
            progress_in = 1'b0;
         end
         OP_RESULT: begin
            mask_in  = ~finished_ff & live_mask;
            count_in = PROC_CNT_W'($countones(~finished_ff & live_mask));
            found_in = |(~finished_ff & live_mask);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_RESOURCES; j++) begin
            avail_ff[j] <= '0;
         end
         finished_ff <= '0;
         progress_ff <= 1'b0;
         ok_ff       <= 1'b1;
         stage_op_ff <= OP_NONE;
      end else begin
         avail_ff    <= avail_in;
         finished_ff <= finished_in;
         progress_ff <= progress_in;
         ok_ff       <= ok_in;
         stage_op_ff <= cmd.op;
      end
   end

   assign status.finished  = finished_ff;
   assign status.progress  = progress_ff;
   assign deadlock_found   = found_ff;
   assign deadlocked_mask  = mask_ff;
   assign deadlocked_count = count_ff;

endmodule

// File: rtl/core/mrdd_ctrl.sv
`include "assert_macros.svh"

module mrdd_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  mrdd_pkg::req_kind_type               req_kind,
   input  logic [mrdd_pkg::PROC_IDX_W-1:0]      req_proc,
   input  logic [mrdd_pkg::RES_IDX_W-1:0]       req_res,
   input  logic [mrdd_pkg::COUNT_WIDTH-1:0]     req_value,
   input  logic [mrdd_pkg::PROC_CNT_W-1:0]      rows,
   input  logic [mrdd_pkg::RES_CNT_W-1:0]       cols,
   input  mrdd_pkg::status_type                 status,
   output mrdd_pkg::cmd_type                    cmd,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);
   import mrdd_pkg::*;

   state_type             state_ff, state_in;
   logic [PROC_CNT_W-1:0] proc_ff, proc_in;
   logic [RES_CNT_W-1:0]  res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         proc_ff      <= '0;
         res_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         proc_ff      <= proc_in;
         res_ff       <= res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      proc_in      = proc_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      req_tready   = 1'b0;
      cmd.op       = OP_NONE;
      cmd.kind     = req_kind;
      cmd.proc     = proc_ff[PROC_IDX_W-1:0];
      cmd.res      = res_ff[RES_IDX_W-1:0];
      cmd.value    = req_value;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind == KIND_RUN) begin
                  cmd.op   = OP_INIT;
                  proc_in  = '0;
                  res_in   = '0;
                  state_in = ST_SUM;
               end else begin
                  cmd.op   = OP_LOAD;
                  cmd.proc = req_proc;
                  cmd.res  = req_res;
               end
            end
         end
         ST_SUM: begin
            if (proc_ff >= rows || cols == '0) begin
               proc_in  = '0;
               res_in   = '0;
               state_in = ST_CHECK;
            end else begin
               cmd.op = OP_SUM;
               if (res_ff == cols - RES_CNT_W'(1)) begin
                  res_in  = '0;
                  proc_in = proc_ff + PROC_CNT_W'(1);
               end else begin
                  res_in = res_ff + RES_CNT_W'(1);
               end
            end
         end
         ST_CHECK: begin
            if (proc_ff >= rows) begin
               if (status.progress) begin
                  cmd.op  = OP_PASS;
                  proc_in = '0;
                  res_in  = '0;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (res_ff == '0 && status.finished[proc_ff[PROC_IDX_W-1:0]]) begin
               proc_in = proc_ff + PROC_CNT_W'(1);
            end else if (res_ff >= cols) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.op = OP_CHECK;
               res_in = res_ff + RES_CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.op   = OP_COMMIT;
            proc_in  = proc_ff + PROC_CNT_W'(1);
            res_in   = '0;
            state_in = ST_CHECK;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_IMPLY(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)
   `ASSERT_NEXT(a_run_starts_sum, clock, reset, req_tvalid && req_tready && req_kind == KIND_RUN, state_ff == ST_SUM)
   `ASSERT_IMPLY(a_commit_after_drain, clock, reset, state_ff == ST_COMMIT, $past(state_ff) == ST_DRAIN)
   `ASSERT_IMPLY(a_sum_col_range, clock, reset, state_ff == ST_SUM && proc_ff < rows && cols != '0, res_ff < cols)

endmodule

// File: dv/multi_resource_deadlock_detector_unit_test.sv
`timescale 1ns / 1ps

module multi_resource_deadlock_detector_unit_test;
   import mrdd_pkg::*;

   localparam int STALL_LIMIT = 120000;
   localparam int HOLD_CYCLES = 20000;

   typedef struct packed {
      logic        found;
      logic [15:0] mask;
      logic [4:0]  count;
   } verdict_type;

   typedef struct {
      req_kind_type kind;
      logic [3:0]   proc_idx;
      logic [2:0]   res_idx;
      logic [7:0]   value;
      bit           typed;
      verdict_type  verdict;
   } probe_row_type;

   localparam verdict_type ALL_FINISHED  = '0;
   localparam verdict_type ONLY_P0_STUCK = '{1'b1, 16'h0001, 5'd1};

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [15:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tready  = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [23:0] rsp_tdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [7:0] units_q  [MAX_RESOURCES];
   logic [7:0] held_q   [MAX_PROCESSES][MAX_RESOURCES];
   logic [7:0] wanted_q [MAX_PROCESSES][MAX_RESOURCES];
   bit         units_set  [MAX_RESOURCES];
   bit         held_set   [MAX_PROCESSES][MAX_RESOURCES];
   bit         wanted_set [MAX_PROCESSES][MAX_RESOURCES];
   logic [4:0] procs_reg = 5'd1;
   logic [3:0] res_reg   = 4'd1;

   verdict_type pending_verdicts[$];
   int       mismatches    = 0;
   int       send_idle_pct = 26;
   int       rcv_idle_pct  = 73;
   int       rsp_hold      = 0;
   int       stall_cycles  = 0;

   probe_row_type probes [22] = '{
      '{KIND_EXIST,   4'd0,  3'd0, 8'd5,   1'b0, ALL_FINISHED},
      '{KIND_ALLOC,   4'd0,  3'd0, 8'd0,   1'b0, ALL_FINISHED},
      '{KIND_REQUEST, 4'd0,  3'd0, 8'd5,   1'b0, ALL_FINISHED},
      '{KIND_RUN,     4'd0,  3'd0, 8'd0,   1'b1, ALL_FINISHED},
      '{KIND_REQUEST, 4'd0,  3'd0, 8'd6,   1'b0, ALL_FINISHED},
      '{KIND_RUN,     4'd0,  3'd0, 8'd0,   1'b1, ONLY_P0_STUCK},
      '{KIND_EXIST,   4'd0,  3'd0, 8'd255, 1'b0, ALL_FINISHED},
      '{KIND_ALLOC,   4'd0,  3'd0, 8'd255, 1'b0, ALL_FINISHED},
      '{KIND_REQUEST, 4'd0,  3'd0, 8'd0,   1'b0, ALL_FINISHED},
      '{KIND_RUN,     4'd0,  3'd0, 8'd0,   1'b1, ALL_FINISHED},
      '{KIND_REQUEST, 4'd0,  3'd0, 8'd1,   1'b0, ALL_FINISHED},
      '{KIND_RUN,     4'd0,  3'd0, 8'd0,   1'b1, ONLY_P0_STUCK},
      '{KIND_EXIST,   4'd0,  3'd0, 8'd0,   1'b0, ALL_FINISHED},
      '{KIND_REQUEST, 4'd0,  3'd0, 8'd0,   1'b0, ALL_FINISHED},
      '{KIND_RUN,     4'd0,  3'd0, 8'd0,   1'b1, ONLY_P0_STUCK},
      '{KIND_ALLOC,   4'd15, 3'd7, 8'd255, 1'b0, ALL_FINISHED},
      '{KIND_REQUEST, 4'd15, 3'd7, 8'd255, 1'b0, ALL_FINISHED},
      '{KIND_EXIST,   4'd15, 3'd7, 8'd255, 1'b0, ALL_FINISHED},
      '{KIND_ALLOC,   4'd0,  3'd0, 8'd0,   1'b0, ALL_FINISHED},
      '{KIND_RUN,     4'd15, 3'd7, 8'd255, 1'b1, ALL_FINISHED},
      '{KIND_REQUEST, 4'd0,  3'd0, 8'd255, 1'b0, ALL_FINISHED},
      '{KIND_RUN,     4'd0,  3'd0, 8'd0,   1'b1, ONLY_P0_STUCK}
   };

   multi_resource_deadlock_detector_unit u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int rows_used();
      return (procs_reg > MAX_PROCESSES) ? MAX_PROCESSES : int'(procs_reg);
   endfunction

   function automatic int cols_used();
      return (res_reg > MAX_RESOURCES) ? MAX_RESOURCES : int'(res_reg);
   endfunction

   function automatic verdict_type compute_verdict();
      int          avail [MAX_RESOURCES];
      bit          done [MAX_PROCESSES];
      bit          progress;
      bit          fits;
      int          rows;
      int          cols;
      verdict_type v;
      rows = rows_used();
      cols = cols_used();
      for (int j = 0; j < cols; j++) begin
         avail[j] = int'(units_q[j]);
         for (int i = 0; i < rows; i++) avail[j] -= int'(held_q[i][j]);
      end
      for (int i = 0; i < MAX_PROCESSES; i++) done[i] = 1'b0;
      do begin
         progress = 1'b0;
         for (int i = 0; i < rows; i++) begin
            if (!done[i]) begin
               fits = 1'b1;
               for (int j = 0; j < cols; j++)
                  if (int'(wanted_q[i][j]) > avail[j]) fits = 1'b0;
               if (fits) begin
                  done[i]  = 1'b1;
                  progress = 1'b1;
                  for (int j = 0; j < cols; j++) avail[j] += int'(held_q[i][j]);
               end
            end
         end
      end while (progress);
      v = '0;
      for (int i = 0; i < rows; i++) begin
         if (!done[i]) begin
            v.mask[i] = 1'b1;
            v.count++;
         end
      end
      v.found = (v.count != 0);
      return v;
   endfunction

   function automatic int column_load(logic [2:0] r);
      int total;
      total = 0;
      for (int i = 0; i < rows_used(); i++)
         if (held_set[i][r]) total += int'(held_q[i][r]);
      return total;
   endfunction

   function automatic logic [7:0] pick_value(req_kind_type kind, logic [2:0] r);
      int total;
      if ($urandom_range(0, 9) < 2) return 8'($urandom);
      case (kind)
         KIND_ALLOC: begin
            return 8'($urandom_range(0, 3));
         end
         KIND_REQUEST: begin
            return 8'($urandom_range(0, 5));
         end
         default: begin
            total = column_load(r) + $urandom_range(0, 4);
            return (total > 255) ? 8'd255 : 8'(total);
         end
      endcase
   endfunction

   function automatic void absorb_request(req_kind_type kind, logic [3:0] p, logic [2:0] r,
                                          logic [7:0] val, bit typed, verdict_type typed_v);
      case (kind)
         KIND_EXIST: begin
            units_q[r]   = val;
            units_set[r] = 1'b1;
         end
         KIND_ALLOC: begin
            held_q[p][r]   = val;
            held_set[p][r] = 1'b1;
         end
         KIND_REQUEST: begin
            wanted_q[p][r]   = val;
            wanted_set[p][r] = 1'b1;
         end
         default: begin
            pending_verdicts.insert(pending_verdicts.size(),
                                    typed ? typed_v : compute_verdict());
         end
      endcase
   endfunction

   function automatic void check_verdict(logic [23:0] word);
      verdict_type got;
      verdict_type want;
      got.found = word[0];
      got.mask  = word[16:1];
      got.count = word[21:17];
      if (pending_verdicts.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: found=%0b mask=%h count=%0d",
                     got.found, got.mask, got.count);
         return;
      end
      want = pending_verdicts.pop_front();
      if (got.found !== want.found || got.mask !== want.mask || got.count !== want.count) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"response mismatch: expected found=%0b mask=%h count=%0d, ",
                      "got found=%0b mask=%h count=%0d"},
                     want.found, want.mask, want.count, got.found, got.mask, got.count);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_hold > 0) begin
            rsp_hold   <= rsp_hold - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
         if (rsp_tvalid && rsp_tready) check_verdict(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("multi_resource_deadlock_detector_unit_test: FAIL");
         $finish;
      end
   end

   task automatic send_request(req_kind_type kind, logic [3:0] p, logic [2:0] r,
                               logic [7:0] val, bit typed, verdict_type typed_v);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, val, r, p};
      do @(posedge clock); while (!req_tready);
      absorb_request(kind, p, r, val, typed, typed_v);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == CSR_IDX_PROCS) procs_reg = val[4:0];
      else res_reg = val[3:0];
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic fill_gaps(int rows, int cols);
      for (int i = 0; i < rows; i++)
         for (int j = 0; j < cols; j++)
            if (!held_set[i][j])
               send_request(KIND_ALLOC, 4'(i), 3'(j), 8'($urandom_range(0, 3)), 1'b0, '0);
      for (int i = 0; i < rows; i++)
         for (int j = 0; j < cols; j++)
            if (!wanted_set[i][j])
               send_request(KIND_REQUEST, 4'(i), 3'(j), 8'($urandom_range(0, 5)), 1'b0, '0);
      for (int j = 0; j < cols; j++)
         if (!units_set[j])
            send_request(KIND_EXIST, 4'($urandom), 3'(j), pick_value(KIND_EXIST, 3'(j)),
                         1'b0, '0);
   endtask

   task automatic run_round();
      int           loads;
      int           rows;
      int           cols;
      logic [3:0]   p;
      logic [2:0]   r;
      req_kind_type kind;
      rows  = rows_used();
      cols  = cols_used();
      loads = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(1, 5);
      repeat (loads) begin
         kind = req_kind_type'($urandom_range(0, 2));
         p = (rows > 0 && $urandom_range(0, 99) < 85) ?
             4'($urandom_range(0, rows - 1)) : 4'($urandom);
         r = (cols > 0 && $urandom_range(0, 99) < 85) ?
             3'($urandom_range(0, cols - 1)) : 3'($urandom);
         send_request(kind, p, r, pick_value(kind, r), 1'b0, '0);
      end
      fill_gaps(rows, cols);
      send_request(KIND_RUN, 4'($urandom), 3'($urandom), 8'($urandom), 1'b0, '0);
   endtask

   task automatic run_phase(logic [4:0] procs, logic [3:0] res, int send_pct, int rcv_pct,
                            int rounds, bit hold);
      settle();
      write_csr(CSR_IDX_PROCS, 32'(procs));
      write_csr(CSR_IDX_RES, 32'(res));
      send_idle_pct = send_pct;
      rcv_idle_pct  = rcv_pct;
      if (hold) rsp_hold <= HOLD_CYCLES;
      repeat (rounds) run_round();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_csr(CSR_IDX_PROCS, 32'd1);
      write_csr(CSR_IDX_RES, 32'd1);
      foreach (probes[k])
         send_request(probes[k].kind, probes[k].proc_idx, probes[k].res_idx, probes[k].value,
                      probes[k].typed, probes[k].verdict);
      run_phase(5'd2, 4'd2, 26, 73, 8, 1'b0);
      run_phase(5'd5, 4'd3, 26, 73, 8, 1'b1);
      run_phase(5'd0, 4'd4, 73, 26, 3, 1'b0);
      run_phase(5'd7, 4'd0, 73, 26, 3, 1'b0);
      run_phase(5'd31, 4'd2, 73, 26, 6, 1'b0);
      run_phase(5'd3, 4'd15, 0, 0, 5, 1'b0);
      run_phase(5'd1, 4'd8, 0, 0, 5, 1'b0);
      run_phase(5'd16, 4'd1, 0, 0, 5, 1'b0);
      settle();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("multi_resource_deadlock_detector_unit_test: PASS");
      end else begin
         $display("multi_resource_deadlock_detector_unit_test: FAIL");
      end
      $finish;
   end

endmodule

// File: multi_resource_deadlock_detector_unit.f
+incdir+rtl/core
rtl/core/mrdd_pkg.sv
rtl/core/mrdd_datapath.sv
rtl/core/mrdd_ctrl.sv
rtl/core/multi_resource_deadlock_detector_unit.sv
dv/multi_resource_deadlock_detector_unit_test.sv
